// ===== sv/flj_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flj_pkg
// Shared types and constants of the frame latency and jitter monitor.
// ----------------------------------------------------------------------------
package flj_pkg;

    localparam int TIME_BITS_DEF = 48;
    localparam int IN_FIXED_BITS = 96;
    localparam int OUT_DATA_W    = 408;
    localparam int CFG_DATA_W    = 48;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_START_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FPS_WINDOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_INTVL  = 2'd2;

    localparam logic [23:0] FPS_WINDOW_RST = 24'd500000;
    localparam logic [23:0] DEF_INTVL_RST  = 24'd33333;

    localparam logic [31:0] FPS_SCALE  = 32'd256000000;
    localparam logic [31:0] FAST_SCALE = 32'd1000000;
    localparam logic [31:0] BR_SCALE   = 32'd8000;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_DROP,
        OP_UPD1,
        OP_UPD2,
        OP_UPD3,
        OP_LAT_DIV,
        OP_JIT_DIV,
        OP_FPS_MUL1,
        OP_FPS_DIV,
        OP_FPS_MUL2,
        OP_FPS_CMP,
        OP_EXP_DIV,
        OP_FPS_END,
        OP_BR_MUL1,
        OP_BR_MUL2,
        OP_BR_DIV,
        OP_DR_DIV,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic is_drop;
        logic drop_nz;
        logic lat_ok;
        logic jit_ok;
        logic fps_due;
        logic fps_fast;
        logic br_due;
        logic total_nz;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

// ===== sv/flj_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flj_div
// Restoring divider, 128-bit dividend by 64-bit divisor, one quotient bit
// per cycle; flags overflow when the upper dividend half reaches the divisor.
// ----------------------------------------------------------------------------
module flj_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_hi,
    input  logic [63:0] i_lo,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic        o_ovf,
    output logic [63:0] o_quo
);

    logic        r_busy;
    logic        r_done;
    logic        r_ovf;
    logic [5:0]  r_cnt;
    logic [63:0] r_hi;
    logic [63:0] r_lo;
    logic [63:0] r_den;
    logic [63:0] r_quo;

    logic [63:0] w_shift;
    logic        w_take;

    assign w_shift = {r_hi[62:0], r_lo[63]};
    assign w_take  = r_hi[63] || (w_shift >= r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_hi  <= i_hi;
                r_lo  <= i_lo;
                r_den <= i_den;
                r_cnt <= '0;
                if (i_hi >= i_den) begin
                    r_ovf  <= 1'b1;
                    r_quo  <= '1;
                    r_done <= 1'b1;
                end else begin
                    r_ovf  <= 1'b0;
                    r_quo  <= '0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_hi  <= w_take ? w_shift - r_den : w_shift;
                r_lo  <= {r_lo[62:0], 1'b0};
                r_quo <= {r_quo[62:0], w_take};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == '1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_ovf  = r_ovf;
    assign o_quo  = r_quo;

endmodule

// ===== sv/flj_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flj_dp
// Statistics datapath: input capture, counters, sums, peaks, the shared
// multiplier and divider, configuration registers and the output register.
// ----------------------------------------------------------------------------
module flj_dp #(
    parameter int TIME_BITS = flj_pkg::TIME_BITS_DEF,
    parameter int IN_DATA_W = ((flj_pkg::IN_FIXED_BITS + 2 * TIME_BITS + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  flj_pkg::t_cmd                  i_cmd,
    output flj_pkg::t_status               o_status,
    input  logic [IN_DATA_W-1:0]           i_s_tdata,
    input  logic                           i_s_tuser,
    input  logic                           i_cfg_we,
    input  logic [flj_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [flj_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [flj_pkg::OUT_DATA_W-1:0] o_m_tdata
);

    localparam int TB = TIME_BITS;

    function automatic logic [47:0] to48(input logic [TB-1:0] v);
        logic [63:0] x;
        x = 64'(v);
        return x[47:0];
    endfunction

    // captured request
    logic          r_act;
    logic [31:0]   r_id;
    logic [31:0]   r_bytes;
    logic [TB-1:0] r_send;
    logic [TB-1:0] r_recv;
    logic [31:0]   r_dcnt;

    logic [TB-1:0] r_start;
    logic [23:0]   r_win;
    logic [23:0]   r_dflt;

    logic [31:0]   r_comp;
    logic [31:0]   r_drop;
    logic [63:0]   r_lat_sum;
    logic [TB-1:0] r_lat_last;
    logic [TB-1:0] r_lat_peak;
    logic [47:0]   r_lat_avg;
    logic [63:0]   r_jit_sum;
    logic [31:0]   r_jit_n;
    logic [TB-1:0] r_jit_last;
    logic [TB-1:0] r_jit_peak;
    logic [47:0]   r_jit_avg;
    logic          r_have_prev;
    logic [TB-1:0] r_prev;
    logic [TB-1:0] r_win_start;
    logic [31:0]   r_faw;
    logic [31:0]   r_fps;
    logic          r_fast;
    logic [TB-1:0] r_exp;
    logic [63:0]   r_bt;
    logic [31:0]   r_br;
    logic [31:0]   r_last_id;
    logic [16:0]   r_dr;

    logic          r_lat_ok;
    logic [TB-1:0] r_lat_diff;
    logic          r_jit_ok;
    logic [TB-1:0] r_jit_val;
    logic [TB-1:0] r_el_w;
    logic [TB-1:0] r_el_b;
    logic [63:0]   r_prod;
    logic [63:0]   r_p0;
    flj_pkg::t_op  r_div_op;

    logic                           r_m_valid;
    logic [flj_pkg::OUT_DATA_W-1:0] r_m_data;

    logic [31:0]   w_delta;
    logic [32:0]   w_total;
    logic [TB-1:0] w_win;
    logic [TB-1:0] w_expect;
    logic [TB-1:0] w_jit_abs;
    logic [31:0]   w_mul_a;
    logic [31:0]   w_mul_b;
    logic [63:0]   w_mul_p;
    logic [63:0]   w_br_lo;
    logic [63:0]   w_br_hi;
    logic          w_br_c;
    logic          w_div_start;
    logic [63:0]   w_div_hi;
    logic [63:0]   w_div_lo;
    logic [63:0]   w_div_den;
    logic          w_div_done;
    logic          w_div_ovf;
    logic [63:0]   w_div_q;
    logic [31:0]   w_q_sat;
    logic [64:0]   w_lat_add;
    logic [64:0]   w_jit_add;
    logic [64:0]   w_bt_add;
    logic [32:0]   w_drop_add;

    assign w_delta  = r_comp - r_faw;
    assign w_total  = {1'b0, r_comp} + {1'b0, r_drop};
    assign w_win    = (r_win == '0) ? TB'(1) : TB'(r_win);
    assign w_expect = r_fast ? r_exp : TB'(r_dflt);
    assign w_jit_abs = (r_jit_val >= w_expect) ? r_jit_val - w_expect
                                               : w_expect - r_jit_val;

    assign w_lat_add  = {1'b0, r_lat_sum} + 65'(r_lat_diff);
    assign w_jit_add  = {1'b0, r_jit_sum} + 65'(r_jit_val);
    assign w_bt_add   = {1'b0, r_bt} + 65'(r_bytes);
    assign w_drop_add = {1'b0, r_drop} + {1'b0, r_dcnt};

    always_comb begin
        unique case (i_cmd.op)
            flj_pkg::OP_FPS_MUL1: begin
                w_mul_a = w_delta;
                w_mul_b = flj_pkg::FPS_SCALE;
            end
            flj_pkg::OP_FPS_MUL2: begin
                w_mul_a = w_delta;
                w_mul_b = flj_pkg::FAST_SCALE;
            end
            flj_pkg::OP_BR_MUL1: begin
                w_mul_a = r_bt[31:0];
                w_mul_b = flj_pkg::BR_SCALE;
            end
            flj_pkg::OP_BR_MUL2: begin
                w_mul_a = r_bt[63:32];
                w_mul_b = flj_pkg::BR_SCALE;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul_p = 64'(w_mul_a) * 64'(w_mul_b);

    assign w_br_lo = r_p0 + {r_prod[31:0], 32'b0};
    assign w_br_c  = w_br_lo < r_p0;
    assign w_br_hi = {32'b0, r_prod[63:32]} + 64'(w_br_c);

    always_comb begin
        w_div_start = 1'b1;
        w_div_hi    = '0;
        w_div_lo    = '0;
        w_div_den   = '0;
        unique case (i_cmd.op)
            flj_pkg::OP_LAT_DIV: begin
                w_div_lo  = r_lat_sum;
                w_div_den = 64'(r_comp);
            end
            flj_pkg::OP_JIT_DIV: begin
                w_div_lo  = r_jit_sum;
                w_div_den = 64'(r_jit_n);
            end
            flj_pkg::OP_FPS_DIV: begin
                w_div_lo  = r_prod;
                w_div_den = 64'(r_el_w);
            end
            flj_pkg::OP_EXP_DIV: begin
                w_div_lo  = 64'(r_el_w);
                w_div_den = 64'(w_delta);
            end
            flj_pkg::OP_BR_DIV: begin
                w_div_hi  = w_br_hi;
                w_div_lo  = w_br_lo;
                w_div_den = 64'(r_el_b);
            end
            flj_pkg::OP_DR_DIV: begin
                w_div_lo  = {16'b0, r_drop, 16'b0};
                w_div_den = 64'(w_total);
            end
            default: w_div_start = 1'b0;
        endcase
    end

    flj_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_hi    (w_div_hi),
        .i_lo    (w_div_lo),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_ovf   (w_div_ovf),
        .o_quo   (w_div_q)
    );

    assign w_q_sat = (w_div_ovf || (w_div_q[63:32] != '0)) ? '1 : w_div_q[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= '0;
            r_win       <= flj_pkg::FPS_WINDOW_RST;
            r_dflt      <= flj_pkg::DEF_INTVL_RST;
            r_comp      <= '0;
            r_drop      <= '0;
            r_lat_sum   <= '0;
            r_lat_last  <= '0;
            r_lat_peak  <= '0;
            r_lat_avg   <= '0;
            r_jit_sum   <= '0;
            r_jit_n     <= '0;
            r_jit_last  <= '0;
            r_jit_peak  <= '0;
            r_jit_avg   <= '0;
            r_have_prev <= 1'b0;
            r_prev      <= '0;
            r_win_start <= '0;
            r_faw       <= '0;
            r_fps       <= '0;
            r_fast      <= 1'b0;
            r_exp       <= TB'(flj_pkg::DEF_INTVL_RST);
            r_bt        <= '0;
            r_br        <= '0;
            r_last_id   <= '0;
            r_dr        <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            if (i_cmd.op == flj_pkg::OP_OUT) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (i_cmd.op)
                flj_pkg::OP_CAPTURE: begin
                    r_act   <= i_s_tuser;
                    r_id    <= i_s_tdata[31:0];
                    r_bytes <= i_s_tdata[63:32];
                    r_send  <= i_s_tdata[64 +: TB];
                    r_recv  <= i_s_tdata[64 + TB +: TB];
                    r_dcnt  <= i_s_tdata[64 + 2 * TB +: 32];
                end
                flj_pkg::OP_DROP: begin
                    if (r_dcnt != '0) begin
                        r_drop <= w_drop_add[32] ? '1 : w_drop_add[31:0];
                    end
                end
                flj_pkg::OP_UPD1: begin
                    if (r_comp != '1) begin
                        r_comp <= r_comp + 32'd1;
                    end
                    r_last_id  <= r_id;
                    r_bt       <= w_bt_add[64] ? '1 : w_bt_add[63:0];
                    r_lat_ok   <= r_recv >= r_send;
                    r_lat_diff <= r_recv - r_send;
                    r_jit_ok   <= r_have_prev;
                    r_jit_val  <= (r_recv >= r_prev) ? r_recv - r_prev : '0;
                    r_el_w     <= r_recv - r_win_start;
                    r_el_b     <= r_recv - r_start;
                end
                flj_pkg::OP_UPD2: begin
                    if (r_lat_ok) begin
                        r_lat_last <= r_lat_diff;
                        if (r_lat_diff > r_lat_peak) begin
                            r_lat_peak <= r_lat_diff;
                        end
                        r_lat_sum <= w_lat_add[64] ? '1 : w_lat_add[63:0];
                    end
                    r_jit_val   <= w_jit_abs;
                    r_prev      <= r_recv;
                    r_have_prev <= 1'b1;
                end
                flj_pkg::OP_UPD3: begin
                    if (r_jit_ok) begin
                        r_jit_last <= r_jit_val;
                        if (r_jit_val > r_jit_peak) begin
                            r_jit_peak <= r_jit_val;
                        end
                        r_jit_sum <= w_jit_add[64] ? '1 : w_jit_add[63:0];
                        if (r_jit_n != '1) begin
                            r_jit_n <= r_jit_n + 32'd1;
                        end
                    end
                end
                flj_pkg::OP_FPS_MUL1: r_prod <= w_mul_p;
                flj_pkg::OP_FPS_MUL2: r_prod <= w_mul_p;
                flj_pkg::OP_BR_MUL1:  r_prod <= w_mul_p;
                flj_pkg::OP_BR_MUL2: begin
                    r_p0   <= r_prod;
                    r_prod <= w_mul_p;
                end
                flj_pkg::OP_FPS_CMP: r_fast <= r_prod > 64'(r_el_w);
                flj_pkg::OP_FPS_END: begin
                    r_faw       <= r_comp;
                    r_win_start <= r_recv;
                end
                flj_pkg::OP_LAT_DIV, flj_pkg::OP_JIT_DIV, flj_pkg::OP_FPS_DIV,
                flj_pkg::OP_EXP_DIV, flj_pkg::OP_BR_DIV, flj_pkg::OP_DR_DIV: begin
                    r_div_op <= i_cmd.op;
                end
                flj_pkg::OP_OUT: begin
                    r_m_data  <= {7'b0, r_dr, r_br, r_fps, r_jit_avg,
                                  to48(r_jit_peak), to48(r_jit_last), r_lat_avg,
                                  to48(r_lat_peak), to48(r_lat_last), r_last_id};
                end
                default: ;
            endcase

            if (w_div_done) begin
                unique case (r_div_op)
                    flj_pkg::OP_LAT_DIV: r_lat_avg <= w_div_q[47:0];
                    flj_pkg::OP_JIT_DIV: r_jit_avg <= w_div_q[47:0];
                    flj_pkg::OP_FPS_DIV: r_fps     <= w_q_sat;
                    flj_pkg::OP_EXP_DIV: r_exp     <= w_div_q[TB-1:0];
                    flj_pkg::OP_BR_DIV:  r_br      <= w_q_sat;
                    flj_pkg::OP_DR_DIV:  r_dr      <= w_div_q[16:0];
                    default: ;
                endcase
            end

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    flj_pkg::CFG_START_TIME: begin
                        r_start     <= TB'(i_cfg_data);
                        r_win_start <= TB'(i_cfg_data);
                    end
                    flj_pkg::CFG_FPS_WINDOW: r_win  <= i_cfg_data[23:0];
                    flj_pkg::CFG_DEF_INTVL:  r_dflt <= i_cfg_data[23:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        o_status.is_drop  = r_act;
        o_status.drop_nz  = r_dcnt != '0;
        o_status.lat_ok   = r_lat_ok;
        o_status.jit_ok   = r_jit_ok;
        o_status.fps_due  = r_el_w >= w_win;
        o_status.fps_fast = r_prod > 64'(r_el_w);
        o_status.br_due   = r_el_b != '0;
        o_status.total_nz = w_total != '0;
        o_status.div_done = w_div_done;
        o_status.out_free = !r_m_valid || i_m_tready;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    a_dr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dr <= 17'd65536)
        else $error("drop rate above one");
    a_lat_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lat_peak >= r_lat_last)
        else $error("latency peak below last latency");
    a_jit_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_jit_peak >= r_jit_last)
        else $error("jitter peak below last jitter");

endmodule

// ===== sv/flj_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flj_ctrl
// Sequencer: steps each request through drop or update, multiply and divide
// operations of the datapath, then hands the result to the output register.
// ----------------------------------------------------------------------------
module flj_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  flj_pkg::t_status i_status,
    output flj_pkg::t_cmd    o_cmd
);

    typedef enum logic [21:0] {
        S_IDLE     = 22'h000001,
        S_DECODE   = 22'h000002,
        S_DROP     = 22'h000004,
        S_UPD1     = 22'h000008,
        S_UPD2     = 22'h000010,
        S_UPD3     = 22'h000020,
        S_LAT_DIV  = 22'h000040,
        S_JIT_DIV  = 22'h000080,
        S_FPS_CHK  = 22'h000100,
        S_FPS_MUL1 = 22'h000200,
        S_FPS_DIV  = 22'h000400,
        S_FPS_MUL2 = 22'h000800,
        S_FPS_CMP  = 22'h001000,
        S_EXP_DIV  = 22'h002000,
        S_FPS_END  = 22'h004000,
        S_BR_CHK   = 22'h008000,
        S_BR_MUL1  = 22'h010000,
        S_BR_MUL2  = 22'h020000,
        S_BR_DIV   = 22'h040000,
        S_DR_CHK   = 22'h080000,
        S_DIV_WAIT = 22'h100000,
        S_OUT      = 22'h200000
    } t_state;

    t_state r_state, n_state;
    t_state r_ret, n_ret;

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        o_cmd.op = flj_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.op = flj_pkg::OP_CAPTURE;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: n_state = i_status.is_drop ? S_DROP : S_UPD1;
            S_DROP: begin
                o_cmd.op = flj_pkg::OP_DROP;
                n_state  = i_status.drop_nz ? S_DR_CHK : S_OUT;
            end
            S_UPD1: begin
                o_cmd.op = flj_pkg::OP_UPD1;
                n_state  = S_UPD2;
            end
            S_UPD2: begin
                o_cmd.op = flj_pkg::OP_UPD2;
                n_state  = S_UPD3;
            end
            S_UPD3: begin
                o_cmd.op = flj_pkg::OP_UPD3;
                priority if (i_status.lat_ok) n_state = S_LAT_DIV;
                else if (i_status.jit_ok)     n_state = S_JIT_DIV;
                else                          n_state = S_FPS_CHK;
            end
            S_LAT_DIV: begin
                o_cmd.op = flj_pkg::OP_LAT_DIV;
                n_ret    = i_status.jit_ok ? S_JIT_DIV : S_FPS_CHK;
                n_state  = S_DIV_WAIT;
            end
            S_JIT_DIV: begin
                o_cmd.op = flj_pkg::OP_JIT_DIV;
                n_ret    = S_FPS_CHK;
                n_state  = S_DIV_WAIT;
            end
            S_FPS_CHK: n_state = i_status.fps_due ? S_FPS_MUL1 : S_BR_CHK;
            S_FPS_MUL1: begin
                o_cmd.op = flj_pkg::OP_FPS_MUL1;
                n_state  = S_FPS_DIV;
            end
            S_FPS_DIV: begin
                o_cmd.op = flj_pkg::OP_FPS_DIV;
                n_ret    = S_FPS_MUL2;
                n_state  = S_DIV_WAIT;
            end
            S_FPS_MUL2: begin
                o_cmd.op = flj_pkg::OP_FPS_MUL2;
                n_state  = S_FPS_CMP;
            end
            S_FPS_CMP: begin
                o_cmd.op = flj_pkg::OP_FPS_CMP;
                n_state  = i_status.fps_fast ? S_EXP_DIV : S_FPS_END;
            end
            S_EXP_DIV: begin
                o_cmd.op = flj_pkg::OP_EXP_DIV;
                n_ret    = S_FPS_END;
                n_state  = S_DIV_WAIT;
            end
            S_FPS_END: begin
                o_cmd.op = flj_pkg::OP_FPS_END;
                n_state  = S_BR_CHK;
            end
            S_BR_CHK: n_state = i_status.br_due ? S_BR_MUL1 : S_DR_CHK;
            S_BR_MUL1: begin
                o_cmd.op = flj_pkg::OP_BR_MUL1;
                n_state  = S_BR_MUL2;
            end
            S_BR_MUL2: begin
                o_cmd.op = flj_pkg::OP_BR_MUL2;
                n_state  = S_BR_DIV;
            end
            S_BR_DIV: begin
                o_cmd.op = flj_pkg::OP_BR_DIV;
                n_ret    = S_DR_CHK;
                n_state  = S_DIV_WAIT;
            end
            S_DR_CHK: begin
                if (i_status.total_nz) begin
                    o_cmd.op = flj_pkg::OP_DR_DIV;
                    n_ret    = S_OUT;
                    n_state  = S_DIV_WAIT;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIV_WAIT: begin
                if (i_status.div_done) begin
                    n_state = r_ret;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.op = flj_pkg::OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_DECODE))
        else $error("accepted request not decoded");
    a_div_ret: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_WAIT && i_status.div_done) |=> (r_state == $past(r_ret)))
        else $error("divider wait returned to wrong step");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !i_status.out_free) |=> (r_state == S_OUT))
        else $error("result dropped while output busy");

endmodule

// ===== sv/frame_latency_jitter_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_latency_jitter_monitor
// One request at a time: a drop request makes one pass of the shared divider
// when its drop count is nonzero, a completion one to six passes. The next
// request is taken once the result is in the output register, so output
// stalls hold it off. Reset is synchronous, active low: statistics clear and
// the configuration registers return to their defaults.
// ----------------------------------------------------------------------------
module frame_latency_jitter_monitor #(
    parameter int TIME_BITS = flj_pkg::TIME_BITS_DEF,
    parameter int IN_DATA_W = ((flj_pkg::IN_FIXED_BITS + 2 * TIME_BITS + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // frame_id, frame_bytes, send_time_us, receive_time_us, drop_count
    input  logic [IN_DATA_W-1:0]           s_axis_tdata,
    // action
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // latest_frame_id, latency_us, max_latency_us, avg_latency_us, jitter_us,
    // max_jitter_us, avg_jitter_us, receive_fps_q8, bitrate_kbps, drop_rate_q16
    output logic [flj_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                           i_cfg_we,
    input  logic [flj_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [flj_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    flj_pkg::t_cmd    w_cmd;
    flj_pkg::t_status w_status;

    flj_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    flj_dp #(
        .TIME_BITS (TIME_BITS),
        .IN_DATA_W (IN_DATA_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata)
    );

endmodule
